>>> rtl/tabx_pkg.sv
`default_nettype none

package tabx_pkg;

    localparam int CHAR_W      = 21;
    localparam int WIDTH_W     = 2;
    localparam int STOP_W      = 12;
    localparam int RUN_W       = 12;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_STOPS   = 6;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 40;

    localparam logic [CHAR_W-1:0] CH_BS    = 21'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 21'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 21'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE = 21'd32;

    // default stop spacing is 8: column bits under the mask give the offset
    localparam logic [2:0] DEFAULT_MASK = 3'o7;

    localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_STOP  = 3'd6;

    localparam logic [CNT_W-1:0] MODE_DEFAULT  = 3'd0;
    localparam logic [CNT_W-1:0] MODE_INTERVAL = 3'd1;

    typedef struct packed {
        logic load;    // capture the accepted word and seed the remainder unit
        logic step;    // one remainder iteration
        logic finish;  // write the result word and the new column
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;  // word on the input is a tab in interval mode
        logic out_free;  // output register can take a word this cycle
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/tabx_ctrl.sv
`default_nettype none

module tabx_ctrl #(
    parameter int COLUMN_BITS = 12
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  tabx_pkg::dp_status_t    status,
    output tabx_pkg::ctrl_cmd_t     cmd
);

    localparam int ITER_W = (COLUMN_BITS > 1) ? $clog2(COLUMN_BITS) : 1;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(COLUMN_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [ITER_W-1:0] iter_reg;

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIV:  cmd.step = 1'b1;
            ST_DONE: cmd.finish = status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    iter_reg <= '0;
                    if (s_tvalid) begin
                        state_reg <= status.need_div ? ST_DIV : ST_DONE;
                    end
                end
                ST_DIV: begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_LAST) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/tabx_datapath.sv
`default_nettype none

module tabx_datapath #(
    parameter int MAX_STOPS   = 6,
    parameter int COLUMN_BITS = 12
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire  [tabx_pkg::IN_DATA_W-1:0]         s_tdata,
    output logic [tabx_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    input  wire                                    cfg_valid,
    input  wire  [tabx_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [tabx_pkg::STOP_W-1:0]            cfg_data,
    input  tabx_pkg::ctrl_cmd_t                    cmd,
    output tabx_pkg::dp_status_t                   status
);

    localparam int SUM_W = ((COLUMN_BITS > tabx_pkg::STOP_W) ?
                            COLUMN_BITS : tabx_pkg::STOP_W) + 1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

    // configuration
    logic [tabx_pkg::CNT_W-1:0]  stop_count_reg;
    logic [tabx_pkg::STOP_W-1:0] stop_reg [tabx_pkg::NUM_STOPS];

    // captured word and column
    logic [tabx_pkg::CHAR_W-1:0]  char_reg;
    logic [tabx_pkg::WIDTH_W-1:0] width_reg;
    logic                         new_file_reg;
    logic [COLUMN_BITS-1:0]       column_reg;

    // remainder unit
    logic [COLUMN_BITS-1:0]       dividend_reg;
    logic [tabx_pkg::STOP_W-1:0]  rem_reg;
    logic [tabx_pkg::STOP_W-1:0]  rem_next;
    logic [tabx_pkg::STOP_W:0]    rem_trial;
    logic [tabx_pkg::STOP_W-1:0]  interval;

    // result path
    logic [tabx_pkg::CHAR_W-1:0]  out_char_reg;
    logic [tabx_pkg::RUN_W-1:0]   repeat_reg;
    logic                         m_tvalid_reg;

    logic [COLUMN_BITS-1:0]       col_in;
    logic [COLUMN_BITS-1:0]       col_eff;
    logic [SUM_W-1:0]             col_ext;
    logic [tabx_pkg::CNT_W-1:0]   used;
    logic [tabx_pkg::RUN_W-1:0]   run_def;
    logic [tabx_pkg::RUN_W-1:0]   run_iv;
    logic [tabx_pkg::RUN_W-1:0]   run_list;
    logic [tabx_pkg::RUN_W-1:0]   run;
    logic [tabx_pkg::RUN_W-1:0]   advance;
    logic [SUM_W-1:0]             col_sum;
    logic [COLUMN_BITS-1:0]       col_new;
    logic [tabx_pkg::CHAR_W-1:0]  out_char;
    logic [tabx_pkg::RUN_W-1:0]   out_run;

    assign interval = (stop_reg[0] == '0) ? tabx_pkg::STOP_W'(1) : stop_reg[0];
    assign used     = (stop_count_reg > tabx_pkg::CNT_W'(MAX_STOPS)) ?
                      tabx_pkg::CNT_W'(MAX_STOPS) : stop_count_reg;

    assign status.need_div = (s_tdata[tabx_pkg::CHAR_W-1:0] == tabx_pkg::CH_TAB) &&
                             (stop_count_reg == tabx_pkg::MODE_INTERVAL);
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign col_in  = s_tdata[tabx_pkg::IN_DATA_W-1] ? '0 : column_reg;
    assign col_eff = new_file_reg ? '0 : column_reg;
    assign col_ext = SUM_W'(col_eff);

    // restoring remainder: one column bit per cycle, MSB first
    assign rem_trial = {rem_reg, dividend_reg[COLUMN_BITS-1]};
    assign rem_next  = (rem_trial >= {1'b0, interval}) ?
                       tabx_pkg::STOP_W'(rem_trial - {1'b0, interval}) :
                       rem_trial[tabx_pkg::STOP_W-1:0];

    assign run_def = tabx_pkg::RUN_W'(4'd8 - {1'b0, col_eff[2:0] & tabx_pkg::DEFAULT_MASK});
    assign run_iv  = interval - rem_reg;

    // first stop in register order beyond the column
    always_comb begin
        logic found;
        found    = 1'b0;
        run_list = tabx_pkg::RUN_W'(1);
        for (int k = 0; k < tabx_pkg::NUM_STOPS; k++) begin
            if (!found && (tabx_pkg::CNT_W'(k) < used) &&
                (SUM_W'(stop_reg[k]) > col_ext)) begin
                found    = 1'b1;
                run_list = tabx_pkg::RUN_W'(SUM_W'(stop_reg[k]) - col_ext);
            end
        end
    end

    always_comb begin
        case (stop_count_reg)
            tabx_pkg::MODE_DEFAULT:  run = run_def;
            tabx_pkg::MODE_INTERVAL: run = run_iv;
            default:                 run = run_list;
        endcase
    end

    always_comb begin
        out_char = char_reg;
        out_run  = tabx_pkg::RUN_W'(1);
        advance  = '0;
        col_new  = col_eff;
        if (char_reg == tabx_pkg::CH_TAB) begin
            out_char = tabx_pkg::CH_SPACE;
            out_run  = run;
            advance  = run;
        end else if (char_reg == tabx_pkg::CH_BS) begin
            if (col_eff != '0) begin
                col_new = col_eff - 1'b1;
            end
        end else if (char_reg == tabx_pkg::CH_NL) begin
            col_new = '0;
        end else begin
            advance = (width_reg == '0) ? tabx_pkg::RUN_W'(1) :
                                          tabx_pkg::RUN_W'(width_reg);
        end
        col_sum = col_ext + SUM_W'(advance);
        if ((char_reg != tabx_pkg::CH_BS) && (char_reg != tabx_pkg::CH_NL)) begin
            col_new = (col_sum > SUM_W'(COL_MAX)) ? COL_MAX :
                                                    col_sum[COLUMN_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_count_reg <= '0;
            for (int k = 0; k < tabx_pkg::NUM_STOPS; k++) begin
                stop_reg[k] <= '0;
            end
            column_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == tabx_pkg::CFG_STOP_COUNT) begin
                    stop_count_reg <= cfg_data[tabx_pkg::CNT_W-1:0];
                end else if (cfg_index <= tabx_pkg::CFG_LAST_STOP) begin
                    stop_reg[tabx_pkg::CFG_IDX_W'(cfg_index - 1'b1)] <= cfg_data;
                end
            end
            if (cmd.finish) begin
                column_reg   <= col_new;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            char_reg     <= s_tdata[tabx_pkg::CHAR_W-1:0];
            width_reg    <= s_tdata[tabx_pkg::CHAR_W +: tabx_pkg::WIDTH_W];
            new_file_reg <= s_tdata[tabx_pkg::IN_DATA_W-1];
            dividend_reg <= col_in;
            rem_reg      <= '0;
        end else if (cmd.step) begin
            dividend_reg <= {dividend_reg[COLUMN_BITS-2:0], 1'b0};
            rem_reg      <= rem_next;
        end
        if (cmd.finish) begin
            out_char_reg <= out_char;
            repeat_reg   <= out_run;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(tabx_pkg::OUT_DATA_W - tabx_pkg::CHAR_W - tabx_pkg::RUN_W){1'b0}},
                       repeat_reg, out_char_reg};

endmodule

`default_nettype wire

>>> rtl/tab_expander.sv
// Tab expander: one character word in, one (character, repeat count) word out.
// Input stream s_*: a word per character; a tab comes out as a space with the
// number of columns up to the next stop, any other character with count 1.
// Result stream m_*: one word per accepted input word, in order.
// Configuration channel cfg_*: index 0 sets the stop count (0 means a stop every
// 8 columns, 1 means a repeat interval given by index 1), indexes 1 to 6 set the
// stop columns. Write it only while no word is in flight; cfg_ready stays high.
// From input accept a word goes to the done state, a tab in interval mode first
// through the divide state, where the column remainder is formed one bit a cycle
// in a restoring remainder unit; the done state writes the output register.
// One word is worked on at a time: no new input word is taken until the last
// one has been written to the output register.
// The output register holds a finished word while m_tready is low, and the next
// input word is still taken and worked up to the point of writing its result.
// Reset (aresetn low, synchronous): column 0, stop count and stops 0, m_tvalid low.
`default_nettype none

module tab_expander #(
    parameter int MAX_STOPS   = 6,
    parameter int COLUMN_BITS = 12
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [tabx_pkg::IN_DATA_W-1:0]       s_tdata,   // char_code, display_width, new_file
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [tabx_pkg::OUT_DATA_W-1:0]      m_tdata,   // out_char, repeat_count, zero pad
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [tabx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [tabx_pkg::STOP_W-1:0]          cfg_data
);

    tabx_pkg::ctrl_cmd_t  cmd;
    tabx_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    tabx_ctrl #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tabx_datapath #(
        .MAX_STOPS   (MAX_STOPS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

>>> rtl/tab_expander_checker.sv
`default_nettype none

module tab_expander_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [tabx_pkg::OUT_DATA_W-1:0]     m_tdata
);

    // a held result word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // every result carries at least one copy
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[tabx_pkg::CHAR_W +: tabx_pkg::RUN_W] != '0)
        else $error("zero repeat count");

    // one word in flight: input closes right after an accept
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in flight");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tab_expander tab_expander_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_STOPS     = 6;
    localparam int COLUMN_BITS   = 12;
    localparam int COL_MAX       = (1 << COLUMN_BITS) - 1;
    localparam int SETTLE_CYCLES = 2 + COLUMN_BITS + 6;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_CHARS   = 250;
    localparam int MAX_REPORTS   = 10;

    localparam logic [tabx_pkg::CFG_IDX_W-1:0] CFG_FIRST_STOP = 3'd1;
    localparam logic [tabx_pkg::CFG_IDX_W-1:0] CFG_UNUSED     = 3'd7;

    // fields from the lowest bit up: char_code, display_width, new_file
    typedef struct packed {
        logic                         new_file;
        logic [tabx_pkg::WIDTH_W-1:0] width;
        logic [tabx_pkg::CHAR_W-1:0]  code;
    } char_word_t;

    typedef struct packed {
        logic [tabx_pkg::CHAR_W-1:0] glyph;
        logic [tabx_pkg::RUN_W-1:0]  reps;
    } glyph_run_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tabx_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tabx_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tabx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tabx_pkg::STOP_W-1:0]     cfg_data = '0;

    // predictor state
    logic [tabx_pkg::CNT_W-1:0]  stop_cnt = '0;
    logic [tabx_pkg::STOP_W-1:0] stop_col [tabx_pkg::NUM_STOPS];
    int                          column = 0;

    char_word_t char_backlog [$];
    glyph_run_t want_runs [$];

    int n_chars_queued = 0;
    int n_chars_taken  = 0;
    int n_tabs_taken   = 0;
    int n_runs_seen    = 0;
    int n_settings     = 0;
    int n_errors       = 0;
    int cycles         = 0;
    int src_chance     = 0;
    int sink_chance    = 0;
    int src_gap        = 0;
    int sink_gap       = 0;

    tab_expander #(
        .MAX_STOPS   (MAX_STOPS),
        .COLUMN_BITS (COLUMN_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d runs outstanding", cycles, want_runs.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void store_reg(input logic [tabx_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [tabx_pkg::STOP_W-1:0] val);
        if (idx == tabx_pkg::CFG_STOP_COUNT) begin
            stop_cnt = val[tabx_pkg::CNT_W-1:0];
        end else if (idx <= tabx_pkg::CFG_LAST_STOP) begin
            stop_col[idx - CFG_FIRST_STOP] = val;
        end
    endfunction

    // spaces needed to reach the next stop from column c
    function automatic int tab_span(input int c);
        int iv;
        int used;
        if (stop_cnt == tabx_pkg::MODE_DEFAULT)
            return 8 - (c & int'(tabx_pkg::DEFAULT_MASK));
        if (stop_cnt == tabx_pkg::MODE_INTERVAL) begin
            iv = (stop_col[0] == 0) ? 1 : int'(stop_col[0]);
            return iv - (c % iv);
        end
        used = (int'(stop_cnt) > MAX_STOPS) ? MAX_STOPS : int'(stop_cnt);
        for (int k = 0; k < used; k++) begin
            if (int'(stop_col[k]) > c) return int'(stop_col[k]) - c;
        end
        return 1;
    endfunction

    function automatic glyph_run_t expand_char(input char_word_t w);
        glyph_run_t r;
        int c;
        int span;
        c = w.new_file ? 0 : column;
        r.glyph = w.code;
        r.reps = tabx_pkg::RUN_W'(1);
        if (w.code == tabx_pkg::CH_TAB) begin
            span = tab_span(c);
            r.glyph = tabx_pkg::CH_SPACE;
            r.reps = span[tabx_pkg::RUN_W-1:0];
            c = c + span;
        end else if (w.code == tabx_pkg::CH_BS) begin
            if (c > 0) c = c - 1;
        end else if (w.code == tabx_pkg::CH_NL) begin
            c = 0;
        end else begin
            c = c + ((w.width == 0) ? 1 : int'(w.width));
        end
        column = (c > COL_MAX) ? COL_MAX : c;
        return r;
    endfunction

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // character source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                want_runs.push_back(expand_char(char_word_t'(s_tdata)));
                n_chars_taken++;
                if (s_tdata[tabx_pkg::CHAR_W-1:0] == tabx_pkg::CH_TAB) n_tabs_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (char_backlog.size() > 0) begin
                    s_tdata <= char_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    if ($urandom_range(1, 100) <= src_chance) src_gap = $urandom_range(1, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // run sink and compare
    always @(posedge aclk) begin
        glyph_run_t want;
        logic [tabx_pkg::CHAR_W-1:0] got_char;
        logic [tabx_pkg::RUN_W-1:0] got_reps;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_char = m_tdata[tabx_pkg::CHAR_W-1:0];
                got_reps = m_tdata[tabx_pkg::CHAR_W +: tabx_pkg::RUN_W];
                n_runs_seen++;
                if (want_runs.size() == 0) begin
                    note_error($sformatf("unexpected word char=%h count=%0d",
                                         got_char, got_reps));
                end else begin
                    want = want_runs.pop_front();
                    if (got_char !== want.glyph)
                        note_error($sformatf("out_char exp %h got %h (run %0d)",
                                             want.glyph, got_char, n_runs_seen));
                    if (got_reps !== want.reps)
                        note_error($sformatf("repeat_count exp %0d got %0d (run %0d)",
                                             want.reps, got_reps, n_runs_seen));
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(1, 100) <= sink_chance) sink_gap = $urandom_range(1, 9);
            end
        end
    end

    task automatic write_reg(input logic [tabx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tabx_pkg::STOP_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        store_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_char(input logic [tabx_pkg::CHAR_W-1:0] code, input int width,
                              input bit nf);
        char_word_t w;
        w.code = code;
        w.width = width[tabx_pkg::WIDTH_W-1:0];
        w.new_file = nf;
        char_backlog.push_back(w);
        n_chars_queued++;
    endtask

    // wait until every queued word is taken and every run is back
    task automatic settle();
        while (n_chars_taken != n_chars_queued || want_runs.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_stops(input int cnt, input int s0, input int s1, input int s2,
                               input int s3, input int s4, input int s5);
        write_reg(tabx_pkg::CFG_STOP_COUNT, cnt[tabx_pkg::STOP_W-1:0]);
        write_reg(CFG_FIRST_STOP, s0[tabx_pkg::STOP_W-1:0]);
        write_reg(tabx_pkg::CFG_IDX_W'(CFG_FIRST_STOP + 1), s1[tabx_pkg::STOP_W-1:0]);
        write_reg(tabx_pkg::CFG_IDX_W'(CFG_FIRST_STOP + 2), s2[tabx_pkg::STOP_W-1:0]);
        write_reg(tabx_pkg::CFG_IDX_W'(CFG_FIRST_STOP + 3), s3[tabx_pkg::STOP_W-1:0]);
        write_reg(tabx_pkg::CFG_IDX_W'(CFG_FIRST_STOP + 4), s4[tabx_pkg::STOP_W-1:0]);
        write_reg(tabx_pkg::CFG_LAST_STOP, s5[tabx_pkg::STOP_W-1:0]);
        n_settings++;
    endtask

    task automatic pick_stops();
        int cnt;
        int s [tabx_pkg::NUM_STOPS];
        int span;
        int at;
        cnt = $urandom_range(0, 7);
        at = $urandom_range(0, 40);
        span = ($urandom_range(0, 2) == 0) ? 8 : (($urandom_range(0, 1) == 0) ? 64 : 700);
        for (int k = 0; k < tabx_pkg::NUM_STOPS; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                s[k] = $urandom_range(0, COL_MAX);  // arbitrary order
            end else begin
                at = at + $urandom_range(1, span);
                s[k] = (at > COL_MAX) ? COL_MAX : at;
            end
        end
        if (cnt == tabx_pkg::MODE_INTERVAL) begin
            case ($urandom_range(0, 5))
                0: s[0] = 0;
                1: s[0] = 1;
                2: s[0] = COL_MAX;
                5: s[0] = $urandom_range(1, COL_MAX);
                default: s[0] = $urandom_range(2, 16);
            endcase
        end
        // stop count uses only the low bits; exercise the rest of the data bus
        cnt = cnt | ($urandom_range(0, 511) << tabx_pkg::CNT_W);
        write_stops(cnt, s[0], s[1], s[2], s[3], s[4], s[5]);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, tabx_pkg::STOP_W'($urandom_range(0, COL_MAX)));
    endtask

    task automatic queue_random_char();
        int r;
        logic [tabx_pkg::CHAR_W-1:0] code;
        r = $urandom_range(0, 99);
        if (r < 28)      code = tabx_pkg::CH_TAB;
        else if (r < 36) code = tabx_pkg::CH_BS;
        else if (r < 42) code = tabx_pkg::CH_NL;
        else if (r < 80) code = tabx_pkg::CHAR_W'($urandom_range(33, 126));
        else if (r < 92) code = tabx_pkg::CHAR_W'($urandom_range(0, 21'h10FFFF));
        else             code = tabx_pkg::CHAR_W'($urandom);
        queue_char(code, $urandom_range(0, 3), $urandom_range(0, 39) == 0);
    endtask

    initial begin
        for (int k = 0; k < tabx_pkg::NUM_STOPS; k++) stop_col[k] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting: stops every 8 columns
        queue_char(tabx_pkg::CH_TAB, 0, 1'b0);
        queue_char(21'h61, 0, 1'b0);
        queue_char(tabx_pkg::CH_TAB, 3, 1'b0);
        queue_char(21'h4E00, 2, 1'b0);
        queue_char(21'h3042, 3, 1'b0);
        queue_char(tabx_pkg::CH_BS, 1, 1'b0);
        queue_char(tabx_pkg::CH_NL, 2, 1'b0);
        queue_char(tabx_pkg::CH_BS, 0, 1'b0);
        queue_char(21'h10FFFF, 1, 1'b0);
        queue_char(21'h1FFFFF, 2, 1'b1);
        queue_char(tabx_pkg::CH_TAB, 1, 1'b1);
        settle();

        // widest interval drives the column to saturation
        write_stops(1, COL_MAX, COL_MAX, COL_MAX, COL_MAX, COL_MAX, COL_MAX);
        queue_char(tabx_pkg::CH_TAB, 0, 1'b1);
        queue_char(21'h78, 3, 1'b0);
        queue_char(tabx_pkg::CH_TAB, 0, 1'b0);
        settle();

        // zero interval acts as one
        write_reg(CFG_FIRST_STOP, '0);
        queue_char(tabx_pkg::CH_TAB, 0, 1'b0);
        queue_char(tabx_pkg::CH_BS, 0, 1'b0);
        settle();

        write_stops(6, 3, 10, 20, 100, 1000, COL_MAX);
        queue_char(tabx_pkg::CH_TAB, 0, 1'b1);
        queue_char(tabx_pkg::CH_TAB, 0, 1'b0);
        queue_char(21'h7A, 2, 1'b0);
        queue_char(tabx_pkg::CH_TAB, 0, 1'b0);
        settle();

        // count above the stop limit, stops out of order
        write_stops(12'hFFF, 50, 10, 30, 60, 5, 70);
        write_reg(CFG_UNUSED, 12'hABC);
        queue_char(tabx_pkg::CH_TAB, 0, 1'b1);
        queue_char(tabx_pkg::CH_TAB, 0, 1'b0);
        queue_char(tabx_pkg::CH_TAB, 0, 1'b0);
        queue_char(tabx_pkg::CH_TAB, 0, 1'b0);
        settle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            pick_stops();
            if (p == RAND_PHASES - 1) begin
                src_chance = 0;
                sink_chance = 0;
            end else begin
                src_chance  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
                sink_chance = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            end
            for (int n = 0; n < PHASE_CHARS; n++) queue_random_char();
            settle();
        end

        $display("covered %0d characters (%0d tabs) under %0d stop settings, %0d runs checked",
                 n_chars_taken, n_tabs_taken, n_settings + 1, n_runs_seen);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/tabx_pkg.sv
rtl/tabx_ctrl.sv
rtl/tabx_datapath.sv
rtl/tab_expander.sv
rtl/tab_expander_checker.sv
sim/tb_top.sv
